// ===== rtl/wshl_pkg.sv =====
// Shared constants and types for the word string hash and length block.
package wshl_pkg;

  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned ROTATE_BITS = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LANE_W      = WORD_BYTES * BYTE_W;
  localparam int unsigned PAD_W       = (LANE_W > DATA_W) ? LANE_W : DATA_W;
  localparam int unsigned IN_BYTES    = DATA_W / BYTE_W;
  localparam int unsigned CNT_W       = $clog2(WORD_BYTES + 1);

  typedef struct packed {
    logic              term;
    logic [DATA_W-1:0] hash;
    logic [DATA_W-1:0] len;
  } merge_res_t;

endpackage

// ===== rtl/wshl_lane.sv =====
// One byte lane: exact zero detect chained with the lanes below it.
module wshl_lane
  import wshl_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              zero_seen_i,
  output logic              zero_seen_o,
  output logic [BYTE_W-1:0] keep_byte_o
);

  always_comb begin
    zero_seen_o = zero_seen_i | (byte_i == '0);
    keep_byte_o = zero_seen_o ? '0 : byte_i;
  end

endmodule

// ===== rtl/wshl_merge.sv =====
// Merges the lane results into the next hash, length and terminator flag.
module wshl_merge
  import wshl_pkg::*;
(
  input  logic [DATA_W-1:0]     word_i,
  input  logic [WORD_BYTES-1:0] zero_seen_i,
  input  logic [PAD_W-1:0]      keep_word_i,
  input  logic [DATA_W-1:0]     run_hash_i,
  input  logic [DATA_W-1:0]     run_len_i,
  output merge_res_t            res_o
);

  logic [DATA_W-1:0] rotated;
  logic [DATA_W-1:0] masked;
  logic [CNT_W-1:0]  lane_cnt;
  logic              term;

  always_comb begin
    rotated = (run_hash_i << ROTATE_BITS) | (run_hash_i >> (DATA_W - ROTATE_BITS));
    term    = zero_seen_i[WORD_BYTES-1];
    masked  = keep_word_i[DATA_W-1:0];
    for (int b = 0; b < IN_BYTES; b++) begin
      if (b >= WORD_BYTES) begin
        masked[b*BYTE_W +: BYTE_W] = '0;
      end
    end
    lane_cnt = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (!zero_seen_i[i]) begin
        lane_cnt = lane_cnt + CNT_W'(1);
      end
    end
    res_o.term = term;
    if (term) begin
      res_o.hash = rotated ^ masked;
      res_o.len  = run_len_i + DATA_W'(lane_cnt);
    end else begin
      res_o.hash = rotated ^ word_i;
      res_o.len  = run_len_i + DATA_W'(WORD_BYTES);
    end
  end

endmodule

// ===== rtl/word_string_hash_and_length_top.sv =====
// Top level of the word string hash and length block.
// A final result is registered in the output register, or in skid when stalled.
// Throughput: one word per cycle while in_stall_o is low.
// An output register with a skid stage keeps input and output decoupled.
// Reset (rst_ni low, asynchronous) clears the running hash, length and all valids.
module word_string_hash_and_length_top
  import wshl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] word_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] hash_out_o,
  output logic [DATA_W-1:0] length_out_o
);

  logic [PAD_W-1:0]      word_pad;
  logic [PAD_W-1:0]      keep_word;
  logic [WORD_BYTES:0]   seen_chain;
  merge_res_t            mres;

  logic [DATA_W-1:0] run_hash_q, run_hash_d;
  logic [DATA_W-1:0] run_len_q, run_len_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_hash_q, out_hash_d;
  logic [DATA_W-1:0] out_len_q, out_len_d;
  logic              skid_valid_q, skid_valid_d;
  logic [DATA_W-1:0] skid_hash_q, skid_hash_d;
  logic [DATA_W-1:0] skid_len_q, skid_len_d;

  logic accept;
  logic out_ready;

  assign word_pad      = PAD_W'(word_in_i);
  assign seen_chain[0] = 1'b0;

  if (PAD_W > LANE_W) begin : g_pad
    assign keep_word[PAD_W-1:LANE_W] = '0;
  end

  for (genvar g = 0; g < WORD_BYTES; g++) begin : g_lane
    wshl_lane u_lane (
      .byte_i      (word_pad[g*BYTE_W +: BYTE_W]),
      .zero_seen_i (seen_chain[g]),
      .zero_seen_o (seen_chain[g+1]),
      .keep_byte_o (keep_word[g*BYTE_W +: BYTE_W])
    );
  end

  wshl_merge u_merge (
    .word_i      (word_in_i),
    .zero_seen_i (seen_chain[WORD_BYTES:1]),
    .keep_word_i (keep_word),
    .run_hash_i  (run_hash_q),
    .run_len_i   (run_len_q),
    .res_o       (mres)
  );

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_ready  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    run_hash_d   = run_hash_q;
    run_len_d    = run_len_q;
    out_valid_d  = out_valid_q;
    out_hash_d   = out_hash_q;
    out_len_d    = out_len_q;
    skid_valid_d = skid_valid_q;
    skid_hash_d  = skid_hash_q;
    skid_len_d   = skid_len_q;
    if (accept) begin
      if (mres.term) begin
        run_hash_d = '0;
        run_len_d  = '0;
      end else begin
        run_hash_d = mres.hash;
        run_len_d  = mres.len;
      end
    end
    if (skid_valid_q && out_ready) begin
      out_valid_d  = 1'b1;
      out_hash_d   = skid_hash_q;
      out_len_d    = skid_len_q;
      skid_valid_d = 1'b0;
    end else if (accept && mres.term) begin
      if (out_ready) begin
        out_valid_d = 1'b1;
        out_hash_d  = mres.hash;
        out_len_d   = mres.len;
      end else begin
        skid_valid_d = 1'b1;
        skid_hash_d  = mres.hash;
        skid_len_d   = mres.len;
      end
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_hash_q   <= '0;
      run_len_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      run_hash_q   <= run_hash_d;
      run_len_q    <= run_len_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q  <= out_hash_d;
    out_len_q   <= out_len_d;
    skid_hash_q <= skid_hash_d;
    skid_len_q  <= skid_len_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_out_o   = out_hash_q;
  assign length_out_o = out_len_q;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid stage holds a result while the output register is empty.");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mres.term) |=> (run_len_q == '0 && run_hash_q == '0))
    else $error("Running state was not cleared after a terminating transaction.");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !mres.term) |=> (run_len_q == $past(run_len_q) + DATA_W'(WORD_BYTES)))
    else $error("Running length did not advance by one word.");
`endif

endmodule
